@@ hw/rtl/wmc_pkg.sv @@
// ----------------------------------------------------------------------------
// wmc_pkg: shared types and constants of the windowed mean clamp block
// Payload structs, register indexes and reset values.
// ----------------------------------------------------------------------------
package wmc_pkg;

  localparam int JOINTS     = 7;
  localparam int JIDX_W     = 3;
  localparam int SAMPLE_W   = 32;
  localparam int WLEN_W     = 7;
  localparam int SAT_W      = 31;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 31;

  localparam logic [JIDX_W-1:0] LAST_JOINT = JIDX_W'(JOINTS - 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_LIMIT     = 2'd1;

  // register reset values (30 samples, 200.0 in Q16.16)
  localparam logic [WLEN_W-1:0] RESET_WINDOW = 7'd30;
  localparam logic [SAT_W-1:0]  RESET_SAT    = 31'd13107200;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] joint0_value;
    logic signed [SAMPLE_W-1:0] joint1_value;
    logic signed [SAMPLE_W-1:0] joint2_value;
    logic signed [SAMPLE_W-1:0] joint3_value;
    logic signed [SAMPLE_W-1:0] joint4_value;
    logic signed [SAMPLE_W-1:0] joint5_value;
    logic signed [SAMPLE_W-1:0] joint6_value;
  } wmc_in_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] joint0_mean;
    logic signed [SAMPLE_W-1:0] joint1_mean;
    logic signed [SAMPLE_W-1:0] joint2_mean;
    logic signed [SAMPLE_W-1:0] joint3_mean;
    logic signed [SAMPLE_W-1:0] joint4_mean;
    logic signed [SAMPLE_W-1:0] joint5_mean;
    logic signed [SAMPLE_W-1:0] joint6_mean;
  } wmc_out_t;

endpackage

@@ hw/rtl/wmc_div.sv @@
// ----------------------------------------------------------------------------
// wmc_div: serial divide and clamp unit
// Restoring divider, one quotient bit per cycle, truncating toward zero,
// followed by a symmetric clamp to +/- lim. Shared over all joints.
// ----------------------------------------------------------------------------
module wmc_div #(
  parameter int SUM_W = 38,
  parameter int CNT_W = 7
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [SUM_W-1:0]            dividend,
  input  logic        [CNT_W-1:0]            divisor,
  input  logic        [wmc_pkg::SAT_W-1:0]   lim,
  output logic                               done,
  output logic signed [wmc_pkg::SAMPLE_W-1:0] result
);
  import wmc_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic                    busy_r,  busy_nxt;
  logic                    done_r,  done_nxt;
  logic [STEP_W-1:0]       step_r,  step_nxt;
  logic [SUM_W-1:0]        quo_r,   quo_nxt;
  logic [CNT_W-1:0]        rem_r,   rem_nxt;
  logic [CNT_W-1:0]        dvs_r,   dvs_nxt;
  logic                    neg_r,   neg_nxt;
  logic signed [SAMPLE_W-1:0] res_r, res_nxt;

  logic [CNT_W:0]          trial;
  logic                    qbit;
  logic [SAT_W-1:0]        mag_c;

  // one restoring step
  assign trial = {rem_r, quo_r[SUM_W-1]};
  assign qbit  = (trial >= {1'b0, dvs_r});
  // clamp the magnitude, sign applied after
  assign mag_c = (quo_r > SUM_W'(lim)) ? lim : quo_r[SAT_W-1:0];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    neg_nxt  = neg_r;
    res_nxt  = res_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = STEP_W'(SUM_W);
      neg_nxt  = dividend[SUM_W-1];
      quo_nxt  = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (step_r != '0) begin
        quo_nxt  = {quo_r[SUM_W-2:0], qbit};
        rem_nxt  = qbit ? CNT_W'(trial - {1'b0, dvs_r}) : trial[CNT_W-1:0];
        step_nxt = step_r - 1'b1;
      end else begin
        // finish: apply sign to clamped magnitude
        res_nxt  = neg_r ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
        done_nxt = 1'b1;
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    neg_r <= neg_nxt;
    res_r <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

`ifndef SYNTHESIS
  // a new division never starts on top of a running one
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r)
    else $error("divider started while busy");
`endif

endmodule

@@ hw/rtl/windowed_mean_clamp_unit.sv @@
// ----------------------------------------------------------------------------
// windowed_mean_clamp_unit: seven-joint moving average with saturation
// Ring store per joint, running sums and a shared serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one beat of seven signed Q16.16 samples.
//   out_valid/out_stall/out_data carry one beat of seven clamped means.
//   cfg_we/cfg_idx/cfg_wdata write window_length (index 0) or sat_limit
//   (index 1); writing window_length clears the sums, slot and wrap flag.
//   Write configuration only while the block is idle.
// Flow:
//   Each beat runs from acceptance through a read state and an update state
//   per joint on the single ring memory port pair, then through the serial
//   divider, one quotient bit per cycle and used once per joint, and on to
//   out_valid. The next beat is taken only once the sequencer is idle again.
//   in_stall is high while a beat is in work; a finished beat waits in the
//   output register, so the next input beat is taken even when the receiver
//   stalls. If the output register is still full when the next result is
//   ready, the block holds that result until the register frees up.
// Reset: window_length 30, sat_limit 200.0, sums and slot cleared. The ring
//   memory is not cleared; entries are used only after the window wraps.
// ----------------------------------------------------------------------------
module windowed_mean_clamp_unit #(
  parameter int WINDOW_MAX = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  wmc_pkg::wmc_in_t                 in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output wmc_pkg::wmc_out_t                out_data,
  input  logic                             cfg_we,
  input  logic [wmc_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [wmc_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import wmc_pkg::*;

  localparam int SLOT_W    = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int CNT_W     = $clog2(WINDOW_MAX + 1);
  localparam int SUM_W     = SAMPLE_W + SLOT_W;
  localparam int MEM_DEPTH = JOINTS * WINDOW_MAX;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  // sequencer states
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_RD       = 3'd1;
  localparam logic [2:0] S_UPD      = 3'd2;
  localparam logic [2:0] S_FIN      = 3'd3;
  localparam logic [2:0] S_DIV_GO   = 3'd4;
  localparam logic [2:0] S_DIV_WAIT = 3'd5;
  localparam logic [2:0] S_OUT      = 3'd6;

  logic [2:0]          state_r,   state_nxt;
  logic [JIDX_W-1:0]   j_r,       j_nxt;
  logic [SLOT_W-1:0]   slot_r,    slot_nxt;
  logic [SLOT_W-1:0]   cur_slot_r, cur_slot_nxt;
  logic                wrapped_r, wrapped_nxt;
  logic [CNT_W-1:0]    count_r,   count_nxt;
  logic [WLEN_W-1:0]   win_len_r, win_len_nxt;
  logic [SAT_W-1:0]    sat_r,     sat_nxt;
  logic                out_valid_r, out_valid_nxt;
  wmc_in_t             in_r;
  wmc_out_t            out_r;

  logic signed [SAMPLE_W-1:0] rd_data_r;
  logic signed [SAMPLE_W-1:0] ring_mem [MEM_DEPTH];
  logic signed [SUM_W-1:0]    sum_r    [JOINTS];
  logic signed [SAMPLE_W-1:0] res_r    [JOINTS];
  logic signed [SAMPLE_W-1:0] in_vec   [JOINTS];

  logic [CNT_W-1:0]           eff_len;
  logic [CNT_W-1:0]           slot_inc;
  logic [ADDR_W-1:0]          mem_addr;
  logic                       mem_we;
  logic signed [SAMPLE_W-1:0] old_s;
  logic signed [SUM_W-1:0]    sum_new;
  logic                       in_acc;
  logic                       out_free;
  logic                       win_clr;
  logic                       div_start;
  logic                       div_done;
  logic signed [SAMPLE_W-1:0] div_result;

  // input vector view
  assign in_vec[0] = in_r.joint0_value;
  assign in_vec[1] = in_r.joint1_value;
  assign in_vec[2] = in_r.joint2_value;
  assign in_vec[3] = in_r.joint3_value;
  assign in_vec[4] = in_r.joint4_value;
  assign in_vec[5] = in_r.joint5_value;
  assign in_vec[6] = in_r.joint6_value;

  // effective window length, held to 1..WINDOW_MAX
  always_comb begin
    if (win_len_r == '0) begin
      eff_len = CNT_W'(1);
    end else if (int'(win_len_r) > WINDOW_MAX) begin
      eff_len = CNT_W'(WINDOW_MAX);
    end else begin
      eff_len = CNT_W'(win_len_r);
    end
  end

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign win_clr  = cfg_we && (cfg_idx == REG_WINDOW_LENGTH);
  assign slot_inc = CNT_W'(cur_slot_r) + 1'b1;
  assign mem_addr = ADDR_W'(int'(j_r) * WINDOW_MAX) + ADDR_W'(cur_slot_r);
  assign mem_we   = (state_r == S_UPD);

  // slot not yet written since the last clear reads as zero
  assign old_s   = wrapped_r ? rd_data_r : '0;
  assign sum_new = sum_r[j_r] - SUM_W'(old_s) + SUM_W'(in_vec[j_r]);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    j_nxt         = j_r;
    slot_nxt      = slot_r;
    cur_slot_nxt  = cur_slot_r;
    wrapped_nxt   = wrapped_r;
    count_nxt     = count_r;
    win_len_nxt   = win_len_r;
    sat_nxt       = sat_r;
    out_valid_nxt = out_valid_r && out_stall;
    div_start     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          cur_slot_nxt = (CNT_W'(slot_r) >= eff_len) ? '0 : slot_r;
          j_nxt        = '0;
          state_nxt    = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        if (j_r == LAST_JOINT) begin
          state_nxt = S_FIN;
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = S_RD;
        end
      end
      S_FIN: begin
        if (slot_inc >= eff_len) begin
          slot_nxt    = '0;
          wrapped_nxt = 1'b1;
          count_nxt   = eff_len;
        end else begin
          slot_nxt  = SLOT_W'(slot_inc);
          count_nxt = wrapped_r ? eff_len : slot_inc;
        end
        j_nxt     = '0;
        state_nxt = S_DIV_GO;
      end
      S_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (div_done) begin
          if (j_r == LAST_JOINT) begin
            state_nxt = S_OUT;
          end else begin
            j_nxt     = j_r + 1'b1;
            state_nxt = S_DIV_GO;
          end
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // configuration writes, to be made only while idle; the block does not enforce it
    if (win_clr) begin
      win_len_nxt = cfg_wdata[WLEN_W-1:0];
      slot_nxt    = '0;
      wrapped_nxt = 1'b0;
    end
    if (cfg_we && (cfg_idx == REG_SAT_LIMIT)) begin
      sat_nxt = cfg_wdata[SAT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      j_r         <= '0;
      slot_r      <= '0;
      cur_slot_r  <= '0;
      wrapped_r   <= 1'b0;
      count_r     <= CNT_W'(1);
      win_len_r   <= RESET_WINDOW;
      sat_r       <= RESET_SAT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      j_r         <= j_nxt;
      slot_r      <= slot_nxt;
      cur_slot_r  <= cur_slot_nxt;
      wrapped_r   <= wrapped_nxt;
      count_r     <= count_nxt;
      win_len_r   <= win_len_nxt;
      sat_r       <= sat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_r <= in_data;
    end
  end

  // ring memory: registered read, write back in the update cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring_mem[mem_addr] <= in_vec[j_r];
    end
    rd_data_r <= ring_mem[mem_addr];
  end

  // running sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < JOINTS; k++) begin
        sum_r[k] <= '0;
      end
    end else if (win_clr) begin
      for (int k = 0; k < JOINTS; k++) begin
        sum_r[k] <= '0;
      end
    end else if (state_r == S_UPD) begin
      sum_r[j_r] <= sum_new;
    end
  end

  // per-joint results
  always_ff @(posedge clk) begin
    if ((state_r == S_DIV_WAIT) && div_done) begin
      res_r[j_r] <= div_result;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if ((state_r == S_OUT) && out_free) begin
      out_r.joint0_mean <= res_r[0];
      out_r.joint1_mean <= res_r[1];
      out_r.joint2_mean <= res_r[2];
      out_r.joint3_mean <= res_r[3];
      out_r.joint4_mean <= res_r[4];
      out_r.joint5_mean <= res_r[5];
      out_r.joint6_mean <= res_r[6];
    end
  end

  wmc_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r[j_r]),
    .divisor  (count_r),
    .lim      (sat_r),
    .done     (div_done),
    .result   (div_result)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  // an accepted beat starts the ring update at joint 0
  a_acc_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == S_RD) && (j_r == '0))
    else $error("accepted beat did not start update");

  // write slot always inside the current window while idle
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (CNT_W'(slot_r) < eff_len))
    else $error("write slot outside window");

  // an output beat that raises out_valid respects the clamp on joint 0
  a_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |->
      (out_r.joint0_mean <= $signed({1'b0, sat_r})) &&
      (out_r.joint0_mean >= -$signed({1'b0, sat_r})))
    else $error("mean outside saturation limit");
`endif

endmodule

@@ bench/tb_windowed_mean_clamp_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_windowed_mean_clamp_unit: self-checking bench of the windowed mean clamp
// Drives seven-joint sample beats through the valid/stall channel and checks
// every mean beat against a cycle-free predictor of the filter. Directed tests
// cover the register extremes, clamping and wrap. Random phases then vary the
// window and the limit, with bursty input and a patterned output stall.
// ----------------------------------------------------------------------------
module tb_windowed_mean_clamp_unit;
  import wmc_pkg::*;

  localparam int WIN_MAX = 64;
  localparam int Q_ONE   = 65536;
  localparam int RANDOM_BEATS = 1400;

  // indexes that map to no register
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED3 = 2'd3;

  typedef enum {STYLE_FULL, STYLE_NEAR, STYLE_EDGE, STYLE_TINY} sample_style_t;
  typedef enum {STALL_OFF, STALL_CHOPPY, STALL_LONG} stall_mode_t;

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  wmc_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  wmc_out_t              out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // predictor state
  logic [WLEN_W-1:0]          win_reg;
  logic [SAT_W-1:0]           sat_reg;
  logic signed [SAMPLE_W-1:0] ring_store [JOINTS][WIN_MAX];
  longint                     joint_sum [JOINTS];
  longint                     fill_slot;
  bit                         wrapped;

  wmc_out_t mean_queue [$];

  int items_sent      = 0;
  int results_checked = 0;
  int cfg_writes      = 0;
  int phases_run      = 0;
  int errors          = 0;
  int burst_left      = 0;

  windowed_mean_clamp_unit #(.WINDOW_MAX(WIN_MAX)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void clear_filter();
    int j;
    int k;
    for (j = 0; j < JOINTS; j++) begin
      joint_sum[j] = 0;
      for (k = 0; k < WIN_MAX; k++) ring_store[j][k] = '0;
    end
    fill_slot = 0;
    wrapped   = 1'b0;
  endfunction

  // Push one beat into the rings and return the clamped means it yields.
  function automatic wmc_out_t predict_means(wmc_in_t beat);
    logic [JOINTS*SAMPLE_W-1:0] flat_in;
    logic [JOINTS*SAMPLE_W-1:0] flat_out;
    logic signed [SAMPLE_W-1:0] x;
    longint len;
    longint count;
    longint lim;
    longint m;
    int j;
    flat_in = beat;
    len = longint'(win_reg);
    if (len == 0) len = 1;
    else if (len > WIN_MAX) len = longint'(WIN_MAX);
    lim = longint'(sat_reg);
    if (fill_slot >= len) fill_slot = 0;
    for (j = 0; j < JOINTS; j++) begin
      x = flat_in[(JOINTS-1-j)*SAMPLE_W +: SAMPLE_W];
      joint_sum[j] = joint_sum[j] - longint'(ring_store[j][fill_slot]) + longint'(x);
      ring_store[j][fill_slot] = x;
    end
    fill_slot++;
    if (fill_slot >= len) begin
      fill_slot = 0;
      wrapped   = 1'b1;
    end
    count = wrapped ? len : fill_slot;
    if (count == 0) count = 1;
    for (j = 0; j < JOINTS; j++) begin
      // longint division truncates toward zero
      m = joint_sum[j] / count;
      if (m > lim) m = lim;
      else if (m < -lim) m = -lim;
      flat_out[(JOINTS-1-j)*SAMPLE_W +: SAMPLE_W] = m[SAMPLE_W-1:0];
    end
    return flat_out;
  endfunction

  // ---------------------------------------------------------------------------
  // Beat builders
  // ---------------------------------------------------------------------------

  function automatic wmc_in_t uniform_beat(logic signed [SAMPLE_W-1:0] v);
    return {JOINTS{v}};
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(sample_style_t style);
    logic signed [SAMPLE_W-1:0] v;
    case (style)
      STYLE_FULL: v = $urandom();
      STYLE_NEAR: begin
        v = $urandom_range(0, 400 * Q_ONE);
        if ($urandom_range(0, 1)) v = -v;
      end
      STYLE_EDGE: begin
        case ($urandom_range(0, 4))
          0:       v = 32'sh7FFFFFFF;
          1:       v = 32'sh80000000;
          2:       v = '0;
          3:       v = -32'sd1;
          default: v = 32'sd1;
        endcase
      end
      default: begin
        v = $urandom_range(0, 16);
        v = v - 8;
      end
    endcase
    return v;
  endfunction

  function automatic wmc_in_t random_beat();
    logic [JOINTS*SAMPLE_W-1:0] flat;
    sample_style_t item_style;
    sample_style_t style;
    int roll;
    int j;
    roll = $urandom_range(0, 99);
    if (roll < 30) item_style = STYLE_FULL;
    else if (roll < 70) item_style = STYLE_NEAR;
    else if (roll < 85) item_style = STYLE_EDGE;
    else item_style = STYLE_TINY;
    for (j = 0; j < JOINTS; j++) begin
      style = item_style;
      if ($urandom_range(0, 4) == 0) style = sample_style_t'($urandom_range(0, 3));
      flat[(JOINTS-1-j)*SAMPLE_W +: SAMPLE_W] = pick_sample(style);
    end
    return flat;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver tasks: all start and end on a falling edge
  // ---------------------------------------------------------------------------

  // Send one sample beat, with burst/gap pacing on the input side.
  task automatic send_beat(input wmc_in_t beat);
    int gap;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 350) : $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= beat;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    mean_queue.push_back(predict_means(beat));
    items_sent++;
    @(negedge clk);
  endtask

  // Hold off input until every expected beat is out, then let the block settle.
  task automatic drain_results(input int settle);
    in_valid <= 1'b0;
    while (mean_queue.size() != 0) @(posedge clk);
    repeat (settle) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    drain_results(8);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      REG_WINDOW_LENGTH: begin
        win_reg = data[WLEN_W-1:0];
        clear_filter();
      end
      REG_SAT_LIMIT: sat_reg = data[SAT_W-1:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_beat
    wmc_out_t want;
    logic [JOINTS*SAMPLE_W-1:0] want_flat;
    logic [JOINTS*SAMPLE_W-1:0] got_flat;
    logic signed [SAMPLE_W-1:0] e;
    logic signed [SAMPLE_W-1:0] a;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (mean_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected mean beat %h", $time, out_data);
      end else begin
        want      = mean_queue.pop_front();
        want_flat = want;
        got_flat  = out_data;
        for (int j = 0; j < JOINTS; j++) begin
          e = want_flat[(JOINTS-1-j)*SAMPLE_W +: SAMPLE_W];
          a = got_flat[(JOINTS-1-j)*SAMPLE_W +: SAMPLE_W];
          if (a !== e) begin
            errors++;
            $display("%0t: joint%0d_mean mismatch: expected %0d, got %0d",
                     $time, j, e, a);
          end
        end
        results_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output stall pattern: quiet stretches, choppy stalls and long holds
  // ---------------------------------------------------------------------------
  stall_mode_t stall_mode = STALL_OFF;
  int  stall_left = 300;
  int  hold_left  = 0;
  bit  hold_level = 1'b0;

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 2));
      stall_left = $urandom_range(200, 1500);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_OFF:    out_stall <= 1'b0;
      STALL_CHOPPY: out_stall <= 1'($urandom_range(0, 1));
      default: begin
        if (hold_left == 0) begin
          hold_level = !hold_level;
          hold_left  = hold_level ? $urandom_range(20, 300) : $urandom_range(1, 40);
        end else begin
          hold_left--;
        end
        out_stall <= hold_level;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset values: window 30, limit 200.0
  task automatic test_reset_defaults();
    send_beat(uniform_beat(10 * Q_ONE));
    send_beat({32'sd32768000, -32'sd32768000, 32'sd0, 32'sd1, -32'sd1,
               32'sd13107200, -32'sd13107201});
    send_beat(uniform_beat(-32'sd3));
    send_beat(uniform_beat(32'sh7FFFFFFF));
  endtask

  // Window of one: each mean is the sample itself, clamped; most negative
  // sample must clamp even at the widest limit.
  task automatic test_window_one();
    write_reg(REG_WINDOW_LENGTH, 31'd1);
    write_reg(REG_SAT_LIMIT, 31'h7FFFFFFF);
    send_beat(uniform_beat(32'sh7FFFFFFF));
    send_beat(uniform_beat(32'sh80000000));
    send_beat({32'sh7FFFFFFF, 32'sh80000000, 32'sd0, -32'sd1, 32'sd1,
               32'sd65536, -32'sd65536});
  endtask

  // Short window that wraps; odd negative sums check truncation toward zero.
  task automatic test_short_wrap();
    write_reg(REG_WINDOW_LENGTH, 31'd3);
    send_beat(uniform_beat(32'sd7));
    send_beat({-32'sd8, 32'sd5, -32'sd1, 32'sd2, -32'sd3, 32'sd9, -32'sd7});
    send_beat(uniform_beat(-32'sd5));
    send_beat({32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 32'sd0,
               -32'sd2, 32'sd4, -32'sd11});
    send_beat(uniform_beat(32'sd2));
  endtask

  // Window zero acts as one, above the maximum acts as the maximum.
  task automatic test_window_extremes();
    write_reg(REG_WINDOW_LENGTH, 31'h80);  // low bits zero
    send_beat(uniform_beat(-32'sd9));
    send_beat(uniform_beat(32'sd12345));
    write_reg(REG_WINDOW_LENGTH, 31'd100);
    send_beat(uniform_beat(32'sh80000000));
    send_beat(uniform_beat(32'sh80000000));
    write_reg(REG_WINDOW_LENGTH, 31'd127);
    send_beat(uniform_beat(-32'sd7));
  endtask

  // Zero limit, limit rewrite keeping state, writes to unused indexes.
  task automatic test_sat_limits();
    write_reg(REG_WINDOW_LENGTH, 31'd4);
    write_reg(REG_SAT_LIMIT, 31'd0);
    send_beat(uniform_beat(32'sh7FFFFFFF));
    send_beat(uniform_beat(-32'sd5000));
    write_reg(REG_SAT_LIMIT, 31'h7FFFFFFF);
    send_beat(uniform_beat(32'sd3));
    write_reg(REG_UNUSED2, 31'd5);
    write_reg(REG_UNUSED3, 31'h7FFFFFFF);
    send_beat(uniform_beat(-32'sd3));
  endtask

  // Random phases: a new limit, mostly with a new window, then a stream sized to wrap most windows.
  task automatic test_random_phases();
    int goal;
    int roll;
    int len;
    int eff;
    int beats;
    logic [CFG_DATA_W-1:0] data;
    goal = items_sent + RANDOM_BEATS;
    while (items_sent < goal) begin
      // window: mostly short, some full, zero and oversize
      if ($urandom_range(0, 4) != 0) begin
        roll = $urandom_range(0, 99);
        if (roll < 40) len = $urandom_range(1, 8);
        else if (roll < 60) len = $urandom_range(9, 40);
        else if (roll < 75) len = WIN_MAX;
        else if (roll < 85) len = 0;
        else len = $urandom_range(WIN_MAX + 1, 127);
        data = CFG_DATA_W'(len);
        if ($urandom_range(0, 3) == 0) data = data | (CFG_DATA_W'($urandom()) << WLEN_W);
        write_reg(REG_WINDOW_LENGTH, data);
      end
      // limit
      roll = $urandom_range(0, 99);
      if (roll < 30) data = RESET_SAT;
      else if (roll < 50) data = 31'h7FFFFFFF;
      else if (roll < 60) data = '0;
      else if (roll < 80) data = CFG_DATA_W'($urandom_range(0, 300 * Q_ONE));
      else data = CFG_DATA_W'($urandom());
      write_reg(REG_SAT_LIMIT, data);

      eff = (win_reg == 0) ? 1 : ((int'(win_reg) > WIN_MAX) ? WIN_MAX : int'(win_reg));
      beats = (eff >= 16) ? $urandom_range(eff + 4, 2 * eff + 10) : $urandom_range(8, 40);
      repeat (beats) send_beat(random_beat());
      phases_run++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    win_reg = RESET_WINDOW;
    sat_reg = RESET_SAT;
    clear_filter();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_reset_defaults();
    test_window_one();
    test_short_wrap();
    test_window_extremes();
    test_sat_limits();
    test_random_phases();

    drain_results(400);
    $display("Run covered %0d sample beats, %0d mean beats checked, %0d register writes,",
             items_sent, results_checked, cfg_writes);
    $display("%0d random phases with window lengths 0..127 and limits 0..max; %0d errors",
             phases_run, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #30_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
